/* rtl/dadd_pkg.sv */
// Shared types, codes and calendar helpers for the date add and difference block.
package dadd_pkg;

    localparam int YEAR_W  = 16;
    localparam int COUNT_W = 22;
    localparam logic [COUNT_W-1:0] DIFF_MAX = {COUNT_W{1'b1}};

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_DIFF = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_LATER = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_date;

    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAY_LAST  = 5'd31;

    // Length of a month; zero for a month code outside January to December.
    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [YEAR_W-1:0] year);
        logic leap;
        logic [4:0] len;
        leap = (year[1:0] == 2'b00);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* rtl/dadd_if.sv */
// Request and result channel interfaces with valid/ready handshake.
interface dadd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
    logic [21:0] add_count;

    modport source (
        output valid, cmd, first_day, first_month, first_year,
               second_day, second_month, second_year, add_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, first_day, first_month, first_year,
               second_day, second_month, second_year, add_count,
        output ready
    );
endinterface

interface dadd_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [21:0] day_difference;
    logic [1:0]  status;

    modport source (
        output valid, out_day, out_month, out_year, day_difference, status,
        input  ready
    );
    modport sink (
        input  valid, out_day, out_month, out_year, day_difference, status,
        output ready
    );
endinterface

/* rtl/date_add_and_difference_core.sv */
// Requests are taken in S_IDLE, stepped one day at a time in S_RUN, and held in S_DONE until the result is taken.
// Add steps add_count days; difference steps from the second date to the first, capped at 4194303.
// Invalid or not-later requests finish with no stepping. One request is in flight at a time.
// Throughput: the next request is taken once the result has been delivered.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops the result valid.
module date_add_and_difference_core
    import dadd_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dadd_in_if.sink         i_req,
    dadd_out_if.source      o_rsp
);

    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    t_date              r_cur, n_cur;
    t_date              r_target, n_target;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [4:0]         r_out_day, n_out_day;
    logic [3:0]         r_out_month, n_out_month;
    logic [13:0]        r_out_year, n_out_year;
    logic [COUNT_W-1:0] r_diff, n_diff;
    t_status            r_status, n_status;

    t_date w_first, w_second, w_next;
    logic  w_ok1, w_ok2, w_at_end;

    assign w_first  = '{year: YEAR_W'(i_req.first_year), month: i_req.first_month,
                        day: i_req.first_day};
    assign w_second = '{year: YEAR_W'(i_req.second_year), month: i_req.second_month,
                        day: i_req.second_day};

    dadd_check #(.MAX_YEAR(MAX_YEAR)) u_check1 (.i_date(w_first),  .o_ok(w_ok1));
    dadd_check #(.MAX_YEAR(MAX_YEAR)) u_check2 (.i_date(w_second), .o_ok(w_ok2));
    dadd_step u_step (.i_date(r_cur), .o_date(w_next));

    assign w_at_end = (r_cur.year == MAX_Y) && (r_cur.month == MONTH_DEC)
                   && (r_cur.day == DAY_LAST);

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = (r_state == S_DONE);
    assign o_rsp.out_day        = r_out_day;
    assign o_rsp.out_month      = r_out_month;
    assign o_rsp.out_year       = r_out_year;
    assign o_rsp.day_difference = r_diff;
    assign o_rsp.status         = r_status;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cur       = r_cur;
        n_target    = r_target;
        n_cnt       = r_cnt;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_diff      = r_diff;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd       = t_cmd'(i_req.cmd);
                    n_out_day   = '0;
                    n_out_month = '0;
                    n_out_year  = '0;
                    n_diff      = '0;
                    n_status    = ST_OK;
                    if (t_cmd'(i_req.cmd) == CMD_ADD) begin
                        if (!w_ok1) begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            n_cur   = w_first;
                            n_cnt   = i_req.add_count;
                            n_state = S_RUN;
                        end
                    end else begin
                        if (!w_ok1 || !w_ok2) begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end else if (w_first <= w_second) begin
                            // Packed year, month, day order compares lexicographically.
                            n_status = ST_NOT_LATER;
                            n_state  = S_DONE;
                        end else begin
                            n_cur    = w_second;
                            n_target = w_first;
                            n_cnt    = '0;
                            n_state  = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (r_cmd == CMD_ADD) begin
                    if (r_cnt == '0) begin
                        n_out_day   = r_cur.day;
                        n_out_month = r_cur.month;
                        n_out_year  = r_cur.year[13:0];
                        n_state     = S_DONE;
                    end else if (w_at_end) begin
                        n_out_day   = DAY_LAST;
                        n_out_month = MONTH_DEC;
                        n_out_year  = MAX_Y[13:0];
                        n_status    = ST_OVERFLOW;
                        n_state     = S_DONE;
                    end else begin
                        n_cur = w_next;
                        n_cnt = r_cnt - COUNT_W'(1);
                    end
                end else begin
                    // Reaching the cap before the target means the true count is larger.
                    if (r_cur == r_target || r_cnt == DIFF_MAX) begin
                        n_diff  = r_cnt;
                        n_state = S_DONE;
                    end else begin
                        n_cur = w_next;
                        n_cnt = r_cnt + COUNT_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cur       <= n_cur;
        r_target    <= n_target;
        r_cnt       <= n_cnt;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_diff      <= n_diff;
        r_status    <= n_status;
    end

endmodule

/* rtl/dadd_check.sv */
// Calendar validity check for one date.
module dadd_check
    import dadd_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  t_date i_date,
    output logic  o_ok
);

    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    logic [4:0] w_len;

    assign w_len = month_len(i_date.month, i_date.year);

    // A zero length also covers month codes outside the year.
    assign o_ok = (w_len != 5'd0) && (i_date.day != 5'd0)
               && (i_date.day <= w_len) && (i_date.year <= MAX_Y);

endmodule

/* rtl/dadd_step.sv */
// Shared date incrementer: advances a date by one calendar day.
module dadd_step
    import dadd_pkg::*;
(
    input  t_date i_date,
    output t_date o_date
);

    logic [4:0] w_len;

    assign w_len = month_len(i_date.month, i_date.year);

    always_comb begin
        o_date = i_date;
        if (i_date.day < w_len) begin
            o_date.day = i_date.day + 5'd1;
        end else begin
            o_date.day = 5'd1;
            if (i_date.month < MONTH_DEC) begin
                o_date.month = i_date.month + 4'd1;
            end else begin
                o_date.month = 4'd1;
                o_date.year  = i_date.year + YEAR_W'(1);
            end
        end
    end

endmodule

/* test/date_add_and_difference_core_tb.sv */
// Self-checking testbench for the calendar date add and day difference core.
module date_add_and_difference_core_tb;
    import dadd_pkg::*;

    localparam int CAL_MAX_YEAR = 9999;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        t_cmd        cmd;
        logic [4:0]  first_day;
        logic [3:0]  first_month;
        logic [13:0] first_year;
        logic [4:0]  second_day;
        logic [3:0]  second_month;
        logic [13:0] second_year;
        logic [21:0] add_count;
    } t_date_req;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic [21:0] day_difference;
        t_status     status;
    } t_date_rsp;

    typedef struct {
        int day;
        int month;
        int year;
    } t_cal_date;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dadd_in_if  req_ch ();
    dadd_out_if rsp_ch ();

    date_add_and_difference_core #(
        .MAX_YEAR(CAL_MAX_YEAR)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    t_date_req pending_reqs[$];
    t_date_rsp expected_rsps[$];
    int        failures      = 0;
    int        send_idle_pct = 0;
    int        rsp_stall_pct = 0;
    bit        req_taken     = 1'b0;
    bit        hold_armed    = 1'b0;
    bit        hold_used     = 1'b0;
    int        hold_left     = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- calendar
    function automatic int days_in_month_of(int m, int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = (y % 4 == 0) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_valid(int d, int m, int y);
        if (m < 1 || m > 12 || d == 0 || y > CAL_MAX_YEAR)
            return 1'b0;
        return d <= days_in_month_of(m, y);
    endfunction

    // Days elapsed since 1 January of year 0.
    function automatic longint day_serial(int d, int m, int y);
        longint s;
        s = 365 * longint'(y) + (longint'(y) + 3) / 4;
        for (int k = 1; k < m && k <= 12; k++)
            s += days_in_month_of(k, y);
        return s + d - 1;
    endfunction

    function automatic t_cal_date date_of_serial(longint s);
        t_cal_date c;
        longint    yr;
        longint    r;
        longint    k;
        int        mo;
        yr = 4 * (s / 1461);
        r  = s % 1461;
        mo = 1;
        if (r >= 366) begin
            r  -= 366;
            k   = r / 365;
            yr += 1 + k;
            r  -= 365 * k;
        end
        while (mo < 12 && r >= days_in_month_of(mo, int'(yr))) begin
            r -= days_in_month_of(mo, int'(yr));
            mo++;
        end
        c.day   = int'(r) + 1;
        c.month = mo;
        c.year  = int'(yr);
        return c;
    endfunction

    function automatic t_cal_date rand_cal_date();
        t_cal_date c;
        int        p;
        p = $urandom_range(99);
        if (p < 10)
            c.year = $urandom_range(CAL_MAX_YEAR, CAL_MAX_YEAR - 4);
        else if (p < 20)
            c.year = $urandom_range(8);
        else
            c.year = $urandom_range(CAL_MAX_YEAR);
        c.month = $urandom_range(12, 1);
        c.day   = $urandom_range(days_in_month_of(c.month, c.year), 1);
        return c;
    endfunction

    function automatic t_date_req make_req(t_cmd cmd, int d1, int m1, int y1,
                                           int d2, int m2, int y2, int n);
        t_date_req r;
        r.cmd          = cmd;
        r.first_day    = d1[4:0];
        r.first_month  = m1[3:0];
        r.first_year   = y1[13:0];
        r.second_day   = d2[4:0];
        r.second_month = m2[3:0];
        r.second_year  = y2[13:0];
        r.add_count    = n[21:0];
        return r;
    endfunction

    // Expected result of one request.
    function automatic t_date_rsp predict_date_op(t_date_req r);
        t_date_rsp res;
        t_cal_date o;
        longint    s1;
        longint    s2;
        longint    smax;
        int        d1;
        int        m1;
        int        y1;
        int        d2;
        int        m2;
        int        y2;
        d1  = int'(r.first_day);
        m1  = int'(r.first_month);
        y1  = int'(r.first_year);
        d2  = int'(r.second_day);
        m2  = int'(r.second_month);
        y2  = int'(r.second_year);
        res = '0;
        res.status = ST_OK;
        if (r.cmd == CMD_ADD) begin
            if (!date_valid(d1, m1, y1)) begin
                res.status = ST_INVALID;
            end else begin
                s1   = day_serial(d1, m1, y1) + longint'(r.add_count);
                smax = day_serial(31, 12, CAL_MAX_YEAR);
                if (s1 > smax) begin
                    res.out_day   = 5'd31;
                    res.out_month = 4'd12;
                    res.out_year  = CAL_MAX_YEAR[13:0];
                    res.status    = ST_OVERFLOW;
                end else begin
                    o             = date_of_serial(s1);
                    res.out_day   = o.day[4:0];
                    res.out_month = o.month[3:0];
                    res.out_year  = o.year[13:0];
                end
            end
        end else begin
            if (!date_valid(d1, m1, y1) || !date_valid(d2, m2, y2)) begin
                res.status = ST_INVALID;
            end else begin
                s1 = day_serial(d1, m1, y1);
                s2 = day_serial(d2, m2, y2);
                if (s1 <= s2)
                    res.status = ST_NOT_LATER;
                else if (s1 - s2 > longint'(DIFF_MAX))
                    res.day_difference = DIFF_MAX;
                else
                    res.day_difference = 22'(s1 - s2);
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus
    task automatic queue_random_items(int count);
        t_date_req r;
        t_cal_date a;
        t_cal_date b;
        t_cal_date t;
        int        sel;
        int        c;
        int        k;
        int        mval;
        longint    cost;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            c   = $urandom_range(99);
            k   = (c < 60) ? $urandom_range(40) :
                  (c < 92) ? $urandom_range(400) : $urandom_range(3000);
            if (sel < 38) begin
                a = rand_cal_date();
                r = make_req(CMD_ADD, a.day, a.month, a.year, $urandom_range(31),
                             $urandom_range(15), $urandom_range(16383), k);
            end else if (sel < 76) begin
                b = rand_cal_date();
                a = date_of_serial(day_serial(b.day, b.month, b.year) + k);
                // Some requests have the first date earlier than the second.
                if ($urandom_range(99) < 15) begin
                    t = a;
                    a = b;
                    b = t;
                end
                r = make_req(CMD_DIFF, a.day, a.month, a.year, b.day, b.month, b.year,
                             $urandom_range(22'h3fffff));
            end else begin
                r = make_req(t_cmd'($urandom_range(1)), $urandom_range(31),
                             $urandom_range(15), $urandom_range(16383), $urandom_range(31),
                             $urandom_range(15), $urandom_range(16383),
                             $urandom_range(22'h3fffff));
                cost = 0;
                if (r.cmd == CMD_ADD &&
                    date_valid(int'(r.first_day), int'(r.first_month), int'(r.first_year)))
                    cost = longint'(r.add_count);
                else if (r.cmd == CMD_DIFF &&
                         date_valid(int'(r.first_day), int'(r.first_month),
                                    int'(r.first_year)) &&
                         date_valid(int'(r.second_day), int'(r.second_month),
                                    int'(r.second_year)))
                    cost = day_serial(int'(r.first_day), int'(r.first_month),
                                      int'(r.first_year)) -
                           day_serial(int'(r.second_day), int'(r.second_month),
                                      int'(r.second_year));
                // Keep long stepping runs rare by spoiling the month of costly requests.
                if (cost > 5000) begin
                    mval          = $urandom_range(3);
                    r.first_month = (mval == 0) ? 4'd0 : 4'(12 + mval);
                end
            end
            pending_reqs.push_back(r);
        end
    endtask

    // Sampled just after the falling edge so that the driver's updates have settled.
    task automatic wait_all_done();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid) begin
            @(negedge i_clk);
            #1;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // ---------------------------------------------------------------- request driver
    always @(negedge i_clk) begin : drive_req
        t_date_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.cmd          <= nxt.cmd;
                req_ch.first_day    <= nxt.first_day;
                req_ch.first_month  <= nxt.first_month;
                req_ch.first_year   <= nxt.first_year;
                req_ch.second_day   <= nxt.second_day;
                req_ch.second_month <= nxt.second_month;
                req_ch.second_year  <= nxt.second_year;
                req_ch.add_count    <= nxt.add_count;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long result hold-off, counted separately from the random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= i_rst_n && hold_left == 0 && ($urandom_range(99) >= rsp_stall_pct);
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin : watch
        t_date_rsp want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
                expected_rsps.push_back(predict_date_op(make_req(
                    t_cmd'(req_ch.cmd), int'(req_ch.first_day), int'(req_ch.first_month),
                    int'(req_ch.first_year), int'(req_ch.second_day),
                    int'(req_ch.second_month), int'(req_ch.second_year),
                    int'(req_ch.add_count))));
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    failures++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("out_day", 32'(want.out_day), 32'(rsp_ch.out_day));
                    check_field("out_month", 32'(want.out_month), 32'(rsp_ch.out_month));
                    check_field("out_year", 32'(want.out_year), 32'(rsp_ch.out_year));
                    check_field("day_difference", 32'(want.day_difference),
                                32'(rsp_ch.day_difference));
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        req_ch.valid        = 1'b0;
        req_ch.cmd          = 1'b0;
        req_ch.first_day    = '0;
        req_ch.first_month  = '0;
        req_ch.first_year   = '0;
        req_ch.second_day   = '0;
        req_ch.second_month = '0;
        req_ch.second_year  = '0;
        req_ch.add_count    = '0;
        rsp_ch.ready        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: calendar corners, invalid dates, overflow, ordering.
        pending_reqs.push_back(make_req(CMD_ADD, 1, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_ADD, 28, 2, 2023, 31, 15, 16383, 1));
        pending_reqs.push_back(make_req(CMD_ADD, 28, 2, 2024, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 12, 1999, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 1, 2020, 0, 0, 0, 30));
        pending_reqs.push_back(make_req(CMD_ADD, 1, 1, 2100, 0, 0, 0, 59));
        pending_reqs.push_back(make_req(CMD_ADD, 29, 2, 2023, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 0, 5, 2000, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 15, 0, 2000, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 15, 13, 2000, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 15, 2000, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 4, 2021, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 1, 1, 10000, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(CMD_ADD, 1, 1, 16383, 0, 0, 0, 22'h3fffff));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 12, 9999, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_ADD, 31, 12, 9999, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(CMD_ADD, 25, 12, 9999, 0, 0, 0, 10));
        pending_reqs.push_back(make_req(CMD_DIFF, 1, 3, 2024, 28, 2, 2024, 22'h3fffff));
        pending_reqs.push_back(make_req(CMD_DIFF, 5, 6, 1987, 5, 6, 1987, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 4, 6, 1987, 5, 6, 1987, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 10, 3, 2001, 10, 0, 2001, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 30, 2, 2001, 10, 1, 2001, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 10, 3, 2001, 10, 1, 16383, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 31, 12, 9999, 1, 12, 9999, 0));
        pending_reqs.push_back(make_req(CMD_DIFF, 1, 1, 1, 31, 12, 0, 0));
        wait_all_done();

        queue_random_items(19);
        wait_all_done();

        send_idle_pct = 47;
        queue_random_items(19);
        wait_all_done();

        // The long hold-off fills the block while requests keep being offered.
        send_idle_pct = 0;
        rsp_stall_pct = 47;
        hold_armed    = 1'b1;
        queue_random_items(19);
        wait_all_done();

        send_idle_pct = 37;
        rsp_stall_pct = 37;
        queue_random_items(19);
        wait_all_done();

        repeat (50) @(posedge i_clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dadd_pkg.sv
rtl/dadd_if.sv
rtl/dadd_check.sv
rtl/dadd_step.sv
rtl/date_add_and_difference_core.sv
test/date_add_and_difference_core_tb.sv
